[rtl/core/dnsax_pkg.sv]
// Package for the DNS answer address extractor: parse phases, the event word
// that passes from the parser to the result stage, and the result word.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package dnsax_pkg;

    localparam int MAX_MESSAGE_BYTES = 4096;
    localparam int POS_W             = $clog2(MAX_MESSAGE_BYTES + 1);

    localparam int HEADER_LAST  = 11;
    localparam int QFIXED_BYTES = 4;
    localparam int AFIXED_LAST  = 9;

    localparam logic [15:0] TYPE_A    = 16'd1;
    localparam logic [15:0] TYPE_AAAA = 16'd28;
    localparam logic [15:0] LEN_A     = 16'd4;
    localparam logic [15:0] LEN_AAAA  = 16'd16;

    localparam logic [7:0] PTR_MASK = 8'hC0;

    // Address kind held in the field counter while RDATA is being taken.
    localparam logic [3:0] FI_NONE = 4'd0;
    localparam logic [3:0] FI_A    = 4'd1;
    localparam logic [3:0] FI_AAAA = 4'd2;
    // In a name, the same counter marks a pending second pointer byte.
    localparam logic [3:0] FI_PTR  = 4'd1;

    localparam logic KIND_ADDR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_QNAME,
        PH_QFIXED,
        PH_ANAME,
        PH_AFIXED,
        PH_RDATA,
        PH_DONE
    } t_phase;

    // What one accepted byte causes: an address, an end summary, or both.
    typedef struct packed {
        logic        has_addr;
        logic        has_end;
        logic        is_ipv6;
        logic [63:0] upper;
        logic [63:0] lower;
        logic [15:0] total;
    } t_event;

    typedef struct packed {
        logic        kind;
        logic        is_ipv6;
        logic [63:0] upper;
        logic [63:0] lower;
        logic [15:0] total;
        logic        run_last;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/dnsax_front.sv]
// Byte parser of the DNS answer address extractor: walks header, questions
// and answer records and raises one event word per byte that yields results.
// Depends on dnsax_pkg.
`default_nettype none

module dnsax_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_final,
    output logic                 o_push,
    output dnsax_pkg::t_event    o_event
);
    import dnsax_pkg::*;

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_qleft, n_qleft;
    logic [15:0]      r_aleft, n_aleft;
    logic [7:0]       r_label, n_label;
    logic [3:0]       r_field, n_field;
    logic [15:0]      r_rtype, n_rtype;
    logic [15:0]      r_rdleft, n_rdleft;
    logic [63:0]      r_shift_hi, n_shift_hi;
    logic [63:0]      r_shift_lo, n_shift_lo;
    logic [15:0]      r_count, n_count;

    always_comb begin
        logic        name_end;
        logic        in_name;
        logic [15:0] ans;
        logic [3:0]  nxt_field;
        logic [1:0]  emit;

        n_phase    = r_phase;
        n_pos      = r_pos;
        n_qleft    = r_qleft;
        n_aleft    = r_aleft;
        n_label    = r_label;
        n_field    = r_field;
        n_rtype    = r_rtype;
        n_rdleft   = r_rdleft;
        n_shift_hi = r_shift_hi;
        n_shift_lo = r_shift_lo;
        n_count    = r_count;
        name_end   = 1'b0;
        in_name    = (r_phase == PH_QNAME) || (r_phase == PH_ANAME);
        ans        = r_aleft;
        nxt_field  = r_field + 4'd1;
        emit       = 2'd0;

        // Shared name walker: label skip, pointer pair or the root byte.
        if (in_name) begin
            if (r_label != 8'd0) begin
                n_label = r_label - 8'd1;
            end else if (r_field == FI_PTR) begin
                n_field  = FI_NONE;
                name_end = 1'b1;
            end else if (i_byte == 8'd0) begin
                name_end = 1'b1;
            end else if ((i_byte & PTR_MASK) == PTR_MASK) begin
                n_field = FI_PTR;
            end else begin
                n_label = i_byte;
            end
        end

        if (r_pos < POS_W'(MAX_MESSAGE_BYTES)) begin
            n_pos = r_pos + POS_W'(1);
            case (r_phase)
                PH_HEADER: begin
                    if (r_pos == POS_W'(4)) n_qleft = {i_byte, 8'h00};
                    else if (r_pos == POS_W'(5)) n_qleft = r_qleft | {8'h00, i_byte};
                    else if (r_pos == POS_W'(6)) n_aleft = {i_byte, 8'h00};
                    else if (r_pos == POS_W'(7)) n_aleft = r_aleft | {8'h00, i_byte};
                    if (r_pos == POS_W'(HEADER_LAST)) begin
                        n_label = 8'd0;
                        n_field = FI_NONE;
                        if (r_qleft != 16'd0) begin
                            n_phase = PH_QNAME;
                        end else begin
                            n_phase = (r_aleft == 16'd0) ? PH_DONE : PH_ANAME;
                        end
                    end
                end
                PH_QNAME: begin
                    if (name_end) begin
                        n_phase = PH_QFIXED;
                        n_field = FI_NONE;
                    end
                end
                PH_QFIXED: begin
                    if (nxt_field >= 4'(QFIXED_BYTES)) begin
                        n_qleft = r_qleft - 16'd1;
                        n_field = FI_NONE;
                        n_label = 8'd0;
                        if (n_qleft != 16'd0) begin
                            n_phase = PH_QNAME;
                        end else begin
                            n_phase = (r_aleft == 16'd0) ? PH_DONE : PH_ANAME;
                        end
                    end else begin
                        n_field = nxt_field;
                    end
                end
                PH_ANAME: begin
                    if (name_end) begin
                        n_phase = PH_AFIXED;
                        n_field = FI_NONE;
                    end
                end
                PH_AFIXED: begin
                    if (r_field == 4'd0) n_rtype = {i_byte, 8'h00};
                    else if (r_field == 4'd1) n_rtype = r_rtype | {8'h00, i_byte};
                    else if (r_field == 4'd8) n_rdleft = {i_byte, 8'h00};
                    else if (r_field == 4'd9) n_rdleft = r_rdleft | {8'h00, i_byte};
                    if (r_field >= 4'(AFIXED_LAST)) begin
                        n_shift_hi = 64'd0;
                        n_shift_lo = 64'd0;
                        if (n_rtype == TYPE_A && n_rdleft == LEN_A) begin
                            n_field = FI_A;
                        end else if (n_rtype == TYPE_AAAA && n_rdleft == LEN_AAAA) begin
                            n_field = FI_AAAA;
                        end else begin
                            n_field = FI_NONE;
                        end
                        if (n_rdleft == 16'd0) begin
                            ans     = r_aleft - 16'd1;
                            n_aleft = ans;
                            n_label = 8'd0;
                            n_field = FI_NONE;
                            n_phase = (ans == 16'd0) ? PH_DONE : PH_ANAME;
                        end else begin
                            n_phase = PH_RDATA;
                        end
                    end else begin
                        n_field = nxt_field;
                    end
                end
                PH_RDATA: begin
                    n_shift_hi = {r_shift_hi[55:0], r_shift_lo[63:56]};
                    n_shift_lo = {r_shift_lo[55:0], i_byte};
                    n_rdleft   = r_rdleft - 16'd1;
                    if (n_rdleft == 16'd0) begin
                        emit    = r_field[1:0];
                        ans     = r_aleft - 16'd1;
                        n_aleft = ans;
                        n_label = 8'd0;
                        n_field = FI_NONE;
                        n_phase = (ans == 16'd0) ? PH_DONE : PH_ANAME;
                    end
                end
                default: begin
                end
            endcase
        end

        if (emit != 2'd0 && r_count != 16'hFFFF) begin
            n_count = r_count + 16'd1;
        end

        o_event.has_addr = (emit == FI_A[1:0]) || (emit == FI_AAAA[1:0]);
        o_event.has_end  = i_final;
        o_event.is_ipv6  = (emit == FI_AAAA[1:0]);
        o_event.upper    = o_event.is_ipv6 ? n_shift_hi : 64'd0;
        o_event.lower    = o_event.is_ipv6 ? n_shift_lo : {32'd0, n_shift_lo[31:0]};
        o_event.total    = n_count;
        o_push           = i_accept && (o_event.has_addr || o_event.has_end);

        // The final byte returns the parser to the start of a message.
        if (i_final) begin
            n_phase  = PH_HEADER;
            n_pos    = '0;
            n_qleft  = 16'd0;
            n_aleft  = 16'd0;
            n_label  = 8'd0;
            n_field  = FI_NONE;
            n_rtype  = 16'd0;
            n_rdleft = 16'd0;
            n_count  = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_qleft  <= 16'd0;
            r_aleft  <= 16'd0;
            r_label  <= 8'd0;
            r_field  <= FI_NONE;
            r_rtype  <= 16'd0;
            r_rdleft <= 16'd0;
            r_count  <= 16'd0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_qleft  <= n_qleft;
            r_aleft  <= n_aleft;
            r_label  <= n_label;
            r_field  <= n_field;
            r_rtype  <= n_rtype;
            r_rdleft <= n_rdleft;
            r_count  <= n_count;
        end
    end

    // The address shift register is cleared before every RDATA field.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_shift_hi <= n_shift_hi;
            r_shift_lo <= n_shift_lo;
        end
    end

endmodule

`default_nettype wire

[rtl/core/dnsax_queue.sv]
// Short event queue between the parser and the result stage.
// Depends on dnsax_pkg for the event word and the queue depth.
`default_nettype none

module dnsax_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire dnsax_pkg::t_event i_data,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_valid,
    output dnsax_pkg::t_event      o_data
);
    import dnsax_pkg::*;

    t_event          r_store [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_count;
    logic            do_pop;

    assign o_full  = (r_count == (Q_AW + 1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_store[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + Q_AW'(1);
            if (do_pop) r_rd <= r_rd + Q_AW'(1);
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + (Q_AW + 1)'(1);
                2'b01:   r_count <= r_count - (Q_AW + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/dnsax_back.sv]
// Result stage: turns each queued event into one or two result words and
// holds the oldest one in the output register. Depends on dnsax_pkg.
`default_nettype none

module dnsax_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire dnsax_pkg::t_event i_q_data,
    output logic                   o_q_pop,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output dnsax_pkg::t_result     o_result
);
    import dnsax_pkg::*;

    logic    r_valid, n_valid;
    logic    r_second, n_second;
    t_result r_out, n_out;
    logic    load;

    always_comb begin
        load     = i_q_valid && (!r_valid || i_pop);
        n_valid  = r_valid && !i_pop;
        n_second = r_second;
        n_out    = r_out;
        o_q_pop  = 1'b0;
        if (load) begin
            n_valid = 1'b1;
            if (i_q_data.has_addr && !r_second) begin
                n_out.kind     = KIND_ADDR;
                n_out.is_ipv6  = i_q_data.is_ipv6;
                n_out.upper    = i_q_data.upper;
                n_out.lower    = i_q_data.lower;
                n_out.total    = 16'd0;
                n_out.run_last = !i_q_data.has_end;
                n_second       = i_q_data.has_end;
                o_q_pop        = !i_q_data.has_end;
            end else begin
                n_out.kind     = KIND_END;
                n_out.is_ipv6  = 1'b0;
                n_out.upper    = 64'd0;
                n_out.lower    = 64'd0;
                n_out.total    = i_q_data.total;
                n_out.run_last = 1'b1;
                n_second       = 1'b0;
                o_q_pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

    // The end half of an event is pending only behind its address word.
    a_second_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> i_q_valid && i_q_data.has_addr && i_q_data.has_end)
        else $error("pending end result without a matching queued event");

    a_second_behind_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> r_valid && r_out.kind == KIND_ADDR && !r_out.run_last)
        else $error("pending end result not behind an address word");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_out.kind == KIND_END |-> r_out.run_last && !r_out.is_ipv6)
        else $error("end result not marked as the last word of its byte");

endmodule

`default_nettype wire

[rtl/core/dns_answer_address_extractor_top.sv]
// Top level of the DNS answer address extractor: byte parser, event queue
// and result stage. Depends on dnsax_pkg, dnsax_front, dnsax_queue, dnsax_back.
`default_nettype none

// The block takes a DNS response one byte a cycle through a queue-style
// push/full port, with i_final_byte set on the last byte of the message, and
// returns words through an empty/pop port. For every complete A record with
// RDLENGTH 4 and every complete AAAA record with RDLENGTH 16 among the answers
// one address word is returned (o_kind low); on the final byte an end word
// with the count of addresses follows (o_kind high), and the parser starts
// afresh for the next message. Compression pointers end a name and are not
// followed; bytes beyond MAX_MESSAGE_BYTES are not parsed. The parser takes one
// byte every cycle while the queue has room; a byte that yields words writes
// one event into a four-entry queue, and the result stage moves one word a
// cycle into its output register unless that holds an unpopped word, so a final
// byte that also completes an address yields two words. A word passes through
// the queue and the output register to the outputs. full rises only when the
// event queue is full, which happens when results are not being popped.

module dns_answer_address_extractor_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_message_byte,
    input  wire logic        i_final_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_kind,
    output logic             o_is_ipv6,
    output logic [63:0]      o_addr_upper,
    output logic [63:0]      o_addr_lower,
    output logic [15:0]      o_address_total,
    output logic             o_run_last
);
    import dnsax_pkg::*;

    logic    accept;
    logic    ev_push;
    t_event  ev_in;
    t_event  ev_head;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    logic    out_valid;
    logic    out_pop;
    t_result result;

    // A byte is taken whenever the event queue has room.
    assign full    = q_full;
    assign accept  = push && !q_full;
    assign empty   = !out_valid;
    assign out_pop = pop && out_valid;

    dnsax_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_message_byte),
        .i_final  (i_final_byte),
        .o_push   (ev_push),
        .o_event  (ev_in)
    );

    dnsax_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ev_push),
        .i_data  (ev_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (ev_head)
    );

    dnsax_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (ev_head),
        .o_q_pop   (q_pop),
        .i_pop     (out_pop),
        .o_valid   (out_valid),
        .o_result  (result)
    );

    assign o_kind          = result.kind;
    assign o_is_ipv6       = result.is_ipv6;
    assign o_addr_upper    = result.upper;
    assign o_addr_lower    = result.lower;
    assign o_address_total = result.total;
    assign o_run_last      = result.run_last;

endmodule

`default_nettype wire
